// ===== design/tscw_pkg.sv =====
// Shared constants and types for the text screen character writer.
package tscw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CHAR_W = 8;

	localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	typedef struct packed {
		logic cr;
		logic lf;
		logic adv;
		logic clr_flag;
	} cur_cmd_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] top;
		logic             flag;
	} cur_state_t;

endpackage

// ===== design/tscw_cursor.sv =====
// Cursor, top-row pointer and scroll flag of the text screen.
module tscw_cursor #(
	parameter int COLUMNS = tscw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tscw_pkg::ROWS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tscw_pkg::cur_cmd_t     cmd,
	output tscw_pkg::cur_state_t   cur,
	output logic                   scroll
);
	import tscw_pkg::*;

	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [RW-1:0] top_q;
	logic          flag_q;

	logic at_last_col;
	logic step_row;

	assign at_last_col = col_q == CW'(COLUMNS - 1);
	assign step_row    = cmd.lf | (cmd.adv & at_last_col);
	assign scroll      = step_row & (row_q == RW'(ROWS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			top_q  <= '0;
			flag_q <= 1'b0;
		end else begin
			if (cmd.cr)
				col_q <= '0;
			if (cmd.adv)
				col_q <= at_last_col ? '0 : col_q + 1'b1;
			if (step_row) begin
				if (scroll) begin
					top_q  <= (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
					flag_q <= 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
			if (cmd.clr_flag)
				flag_q <= 1'b0;
		end
	end

	assign cur.col  = COL_W'(col_q);
	assign cur.row  = ROW_W'(row_q);
	assign cur.top  = ROW_W'(top_q);
	assign cur.flag = flag_q;

endmodule

// ===== design/text_screen_char_writer.sv =====
// Top level: text screen store fed by received characters, with cell reads.
//
//  port group | dir | fields (low bit up)
//  s_*        | in  | tdata: char_code, read_row, read_col; tuser: req_type; tlast: batch_end
//  m_*        | out | tdata: cursor_col, cursor_row, scrolled_in_batch, read_char
//
// CR, LF, an out-of-range read and a character into a touched row pass through
// ST_EXEC and ST_FIN between accepts.
// The first character into a row untouched since reset or scroll also fills the row in ST_SWEEP,
// one cell per cycle through the single write port.
// An in-range read also passes ST_RD and ST_RDATA, for the registered read port of the screen memory.
// Scrolling rotates a top-row pointer; no memory copy. Reset ends with no sweep.
// A finished result waits in the output register; input is held off only
// while the sequencer is busy or a second result cannot be placed.
module text_screen_char_writer #(
	parameter int COLUMNS = tscw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tscw_pkg::ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13], zeros
	input  logic        s_tuser,  // req_type
	input  logic        s_tlast,  // batch_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // cursor_col[6:0], cursor_row[11:7],
	                              // scrolled_in_batch[12], read_char[20:13], zeros
);
	import tscw_pkg::*;

	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = ROWS * (1 << CW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_RD,
		ST_RDATA,
		ST_FIN
	} state_t;

	state_t state_q;

	logic              req_q;
	logic [CHAR_W-1:0] code_q;
	logic [ROW_W-1:0]  rrow_q;
	logic [COL_W-1:0]  rcol_q;
	logic              bend_q;

	logic [CW-1:0]     sweep_col_q;
	logic [AW-1:0]     raddr_q;
	logic              rowok_q;
	logic [CHAR_W-1:0] rdata_q;
	logic [CHAR_W-1:0] rchar_q;
	logic [ROWS-1:0]   valid_q;

	logic              m_tvalid_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic              out_flag_q;
	logic [CHAR_W-1:0] out_char_q;

	logic [CHAR_W-1:0] mem [DEPTH];

	cur_cmd_t   cmd;
	cur_state_t cur;
	logic       scroll;

	logic [RW-1:0]     row_sel;
	logic [RW:0]       row_sum;
	logic [RW:0]       row_wrap;
	logic [RW-1:0]     phys;
	logic              rd_in_range;
	logic              is_write;
	logic              is_cr;
	logic              is_lf;
	logic              printable;
	logic              row_ok;
	logic              sweep_last;
	logic              out_load;
	logic              mem_we;
	logic [AW-1:0]     waddr;
	logic [CHAR_W-1:0] wdata;

	tscw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_cursor (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.cur   (cur),
		.scroll(scroll)
	);

	// logical row to physical row: one add and one compare-subtract
	assign row_sel  = (req_q == REQ_READ) ? rrow_q[RW-1:0] : cur.row[RW-1:0];
	assign row_sum  = {1'b0, cur.top[RW-1:0]} + {1'b0, row_sel};
	assign row_wrap = row_sum - (RW+1)'(ROWS);
	assign phys     = (row_sum >= (RW+1)'(ROWS)) ? row_wrap[RW-1:0] : row_sum[RW-1:0];

	assign rd_in_range = ({1'b0, rrow_q} < (ROW_W+1)'(ROWS)) &&
	                     ({1'b0, rcol_q} < (COL_W+1)'(COLUMNS));
	assign is_write    = req_q == REQ_WRITE;
	assign is_cr       = code_q == CODE_CR;
	assign is_lf       = code_q == CODE_LF;
	assign printable   = is_write && !is_cr && !is_lf;
	assign row_ok      = valid_q[phys];
	assign sweep_last  = sweep_col_q == CW'(COLUMNS - 1);
	assign out_load    = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	assign cmd.cr       = (state_q == ST_EXEC) && is_write && is_cr;
	assign cmd.lf       = (state_q == ST_EXEC) && is_write && is_lf;
	assign cmd.adv      = ((state_q == ST_EXEC) && printable && row_ok) ||
	                      ((state_q == ST_SWEEP) && sweep_last);
	assign cmd.clr_flag = out_load && bend_q;

	assign mem_we = ((state_q == ST_EXEC) && printable && row_ok) || (state_q == ST_SWEEP);
	assign waddr  = {phys, (state_q == ST_SWEEP) ? sweep_col_q : cur.col[CW-1:0]};
	assign wdata  = ((state_q == ST_SWEEP) && (sweep_col_q != cur.col[CW-1:0])) ?
	                CODE_SPACE : code_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= REQ_WRITE;
			code_q      <= '0;
			rrow_q      <= '0;
			rcol_q      <= '0;
			bend_q      <= 1'b0;
			sweep_col_q <= '0;
			raddr_q     <= '0;
			rowok_q     <= 1'b0;
			rchar_q     <= '0;
			valid_q     <= '0;
			m_tvalid_q  <= 1'b0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_flag_q  <= 1'b0;
			out_char_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !out_load)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						req_q   <= s_tuser;
						code_q  <= s_tdata[7:0];
						rrow_q  <= s_tdata[12:8];
						rcol_q  <= s_tdata[19:13];
						bend_q  <= s_tlast;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					rchar_q <= '0;
					if (!is_write) begin
						if (rd_in_range) begin
							raddr_q <= {phys, rcol_q[CW-1:0]};
							rowok_q <= row_ok;
							state_q <= ST_RD;
						end else begin
							state_q <= ST_FIN;
						end
					end else if (printable && !row_ok) begin
						sweep_col_q <= '0;
						state_q     <= ST_SWEEP;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_SWEEP: begin
					if (sweep_last) begin
						valid_q[phys] <= 1'b1;
						state_q       <= ST_FIN;
					end else begin
						sweep_col_q <= sweep_col_q + 1'b1;
					end
				end
				ST_RD: begin
					state_q <= ST_RDATA;
				end
				ST_RDATA: begin
					rchar_q <= rowok_q ? rdata_q : CODE_SPACE;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						out_col_q  <= cur.col;
						out_row_q  <= cur.row;
						out_flag_q <= cur.flag;
						out_char_q <= rchar_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// the row leaving the top becomes the blank bottom row
			if (scroll)
				valid_q[cur.top[RW-1:0]] <= 1'b0;
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_char_q, out_flag_q, out_row_q, out_col_q};

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cur.col} < (COL_W+1)'(COLUMNS))
		else $error("cursor column out of range");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cur.row} < (ROW_W+1)'(ROWS))
		else $error("cursor row out of range");

	a_sweep_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> !row_ok)
		else $error("row fill on a row already in use");

	a_fin_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid && (state_q == ST_IDLE))
		else $error("finished item not presented");

endmodule

// ===== test/text_screen_char_writer_test.sv =====
`timescale 1ns / 100ps
// Testbench for text_screen_char_writer: screen writes, cell reads, scrolling and stalls.
module text_screen_char_writer_test;
	import tscw_pkg::*;

	localparam int N_COLS      = COLUMNS_DEF;
	localparam int N_ROWS      = ROWS_DEF;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 150;

	typedef struct {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              scrolled;
		logic [CHAR_W-1:0] rchar;
	} status_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // char_code, read_row, read_col, zeros
	logic        s_tuser;   // req_type
	logic        s_tlast;   // batch_end
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // cursor_col, cursor_row, scrolled_in_batch, read_char, zeros

	logic [CHAR_W-1:0] screen [N_ROWS][N_COLS];
	int      cur_col;
	int      cur_row;
	bit      scroll_flag;
	status_t expected_status [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request  = 0;
	int errors        = 0;
	int n_items       = 0;
	int n_reads       = 0;
	int n_scrolls     = 0;
	int n_batch_ends  = 0;
	int n_results     = 0;
	int quiet_cycles  = 0;

	text_screen_char_writer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// predictor
	function automatic void clear_screen();
		for (int r = 0; r < N_ROWS; r++)
			for (int c = 0; c < N_COLS; c++)
				screen[r][c] = CODE_SPACE;
		cur_col     = 0;
		cur_row     = 0;
		scroll_flag = 1'b0;
	endfunction

	function automatic void line_feed();
		if (cur_row == N_ROWS - 1) begin
			for (int r = 0; r < N_ROWS - 1; r++)
				for (int c = 0; c < N_COLS; c++)
					screen[r][c] = screen[r + 1][c];
			for (int c = 0; c < N_COLS; c++)
				screen[N_ROWS - 1][c] = CODE_SPACE;
			scroll_flag = 1'b1;
			n_scrolls++;
		end else begin
			cur_row++;
		end
	endfunction

	function automatic void predict_status(input logic req, input logic [7:0] code,
			input logic [4:0] rrow, input logic [6:0] rcol, input logic bend);
		status_t s;
		s.rchar = '0;
		if (req == REQ_READ) begin
			n_reads++;
			if (rrow < N_ROWS && rcol < N_COLS)
				s.rchar = screen[rrow][rcol];
		end else if (code == CODE_CR) begin
			cur_col = 0;
		end else if (code == CODE_LF) begin
			line_feed();
		end else begin
			screen[cur_row][cur_col] = code;
			cur_col++;
			if (cur_col == N_COLS) begin
				cur_col = 0;
				line_feed();
			end
		end
		s.col      = cur_col;
		s.row      = cur_row;
		s.scrolled = scroll_flag;
		expected_status.push_back(s);
		if (bend) begin
			scroll_flag = 1'b0;
			n_batch_ends++;
		end
	endfunction

	// stimulus
	task automatic send_item(input logic req, input logic [7:0] code, input logic [4:0] rrow,
			input logic [6:0] rcol, input logic bend);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata  <= {4'b0, rcol, rrow, code};
		s_tuser  <= req;
		s_tlast  <= bend;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_items++;
		predict_status(req, code, rrow, rcol, bend);
		@(negedge clk);
	endtask

	task automatic send_write(input logic [7:0] code, input logic bend);
		send_item(REQ_WRITE, code, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)), bend);
	endtask

	task automatic send_read(input logic [4:0] rrow, input logic [6:0] rcol, input logic bend);
		send_item(REQ_READ, 8'($urandom_range(0, 255)), rrow, rcol, bend);
	endtask

	task automatic rest_and_drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (expected_status.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic rand_batch_end();
		return $urandom_range(0, 7) == 0;
	endfunction

	function automatic logic [7:0] text_byte();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(8'h20, 8'h7E));
	endfunction

	task automatic random_read();
		int pick;
		logic [4:0] r;
		logic [6:0] c;
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			r = 5'(cur_row);
			c = 7'($urandom_range(0, N_COLS - 1));
		end else if (pick < 9) begin
			r = 5'($urandom_range(0, N_ROWS - 1));
			c = 7'($urandom_range(0, N_COLS - 1));
		end else begin
			r = 5'($urandom_range(0, 31));
			c = 7'($urandom_range(0, 127));
		end
		send_read(r, c, rand_batch_end());
	endtask

	// one line of text with or without a line end, a few reads, a burst of line feeds or raw noise
	task automatic random_chunk();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 24);
			repeat (len)
				send_write(text_byte(), rand_batch_end());
			case ($urandom_range(0, 3))
				0: begin
					send_write(CODE_CR, 1'b0);
					send_write(CODE_LF, rand_batch_end());
				end
				1: send_write(CODE_LF, rand_batch_end());
				2: send_write(CODE_CR, rand_batch_end());
				default: ;
			endcase
		end else if (pick < 80) begin
			repeat ($urandom_range(1, 4))
				random_read();
		end else if (pick < 90) begin
			repeat ($urandom_range(1, 6))
				send_write(CODE_LF, rand_batch_end());
		end else begin
			repeat ($urandom_range(1, 8))
				send_write(8'($urandom_range(0, 255)), rand_batch_end());
		end
	endtask

	// tests
	task automatic test_cell_reads();
		send_write(8'h41, 1'b0);
		send_write(8'hFF, 1'b0);
		send_write(8'h00, 1'b0);
		send_write(CODE_CR, 1'b0);
		send_read(5'd0, 7'd0, 1'b0);
		send_read(5'd0, 7'd1, 1'b0);
		send_read(5'd0, 7'd2, 1'b0);
		send_read(5'(N_ROWS - 1), 7'(N_COLS - 1), 1'b0);
		send_read(5'(N_ROWS), 7'd0, 1'b0);
		send_read(5'd0, 7'(N_COLS), 1'b0);
		send_read(5'd31, 7'd127, 1'b1);
		send_write(CODE_LF, 1'b1);
		send_write(8'h42, 1'b0);
		send_read(5'd1, 7'd0, 1'b0);
		rest_and_drain();
	endtask

	task automatic test_scroll_flag();
		send_write(CODE_CR, 1'b0);
		while (cur_row < N_ROWS - 1)
			send_write(CODE_LF, 1'b0);
		send_write(CODE_LF, 1'b1);   // scroll on the batch end item itself
		send_read(5'(N_ROWS - 2), 7'd0, 1'b0);
		send_write(CODE_LF, 1'b0);
		send_read(5'd0, 7'd0, 1'b1);
		send_read(5'd0, 7'd0, 1'b0);
		rest_and_drain();
	endtask

	task automatic test_random_text(input int count);
		int start;
		start = n_items;
		while (n_items - start < count)
			random_chunk();
	endtask

	task automatic test_output_stall();
		int start;
		start = n_items;
		hold_request = HOLD_CYCLES;
		while (n_items - start < 40)
			random_chunk();
		rest_and_drain();
	endtask

	// receiver
	always @(negedge clk) begin : receiver
		int hold_left;
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : status_check
		status_t want;
		if (m_tvalid && m_tready) begin
			n_results++;
			if (expected_status.size() == 0) begin
				errors++;
				$display("%0t: result expected none, got 0x%06h", $time, m_tdata);
			end else begin
				want = expected_status.pop_front();
				check_field("cursor_col", want.col, m_tdata[6:0]);
				check_field("cursor_row", want.row, m_tdata[11:7]);
				check_field("scrolled_in_batch", want.scrolled, m_tdata[12]);
				check_field("read_char", want.rchar, m_tdata[20:13]);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		clear_screen();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 12;
		recv_idle_pct = 62;
		test_cell_reads();
		test_scroll_flag();
		test_random_text(460);

		send_idle_pct = 62;
		recv_idle_pct = 12;
		test_random_text(460);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_output_stall();
		test_random_text(400);

		rest_and_drain();
		repeat (10) @(posedge clk);

		$display("Sent %0d items (%0d cell reads, %0d batch ends), %0d scrolls predicted",
			n_items, n_reads, n_batch_ends, n_scrolls);
		$display("Checked %0d results with %0d mismatches", n_results, errors);
		if (errors == 0 && expected_status.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
